// ----- rtl/lhf_pkg.sv -----
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared types, codes and constants of the label map hole fill unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lhf_pkg;

    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 65536;
    localparam int CNT_W       = 17;
    localparam int LABEL_W     = 8;

    localparam logic [LABEL_W-1:0] MARK      = 8'd255;
    localparam logic [LABEL_W-1:0] TOP_LABEL = 8'd254;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_FILL_ENABLE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // neighbor directions: left, right, up, down
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_NOP,
        CMD_RUN_INIT,
        CMD_CP_RD,
        CMD_CP_WR,
        CMD_GR_INIT,
        CMD_POP_RD,
        CMD_POP_LD,
        CMD_NB_RD,
        CMD_NB_EV,
        CMD_P_ZERO,
        CMD_SC_RD,
        CMD_SC_EV,
        CMD_SC_NEXT,
        CMD_WB_INIT,
        CMD_WB_RD,
        CMD_WB_WR,
        CMD_FN_RD,
        CMD_FN_WR
    } t_cmd;

    typedef struct packed {
        logic p_last;
        logic fill_zero;
        logic head_lt;
        logic dir_last;
        logic k_lt;
    } t_status;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/label_map_hole_fill_unit.sv -----
// ----------------------------------------------------------------------------
// label_map_hole_fill_unit
// Plane label image store with enclosed hole filling on a run request.
// ----------------------------------------------------------------------------
// channel   | handshake                        | payload
// request   | start, accepted when !busy       | i_op, i_pixel_index, i_label_in
// result    | o_valid, one cycle strobe        | o_label_out
// config    | i_cfg_valid / o_cfg_ready (=1)   | i_cfg_index, i_cfg_data
//
// Write and read requests do not make the unit busy; a read answers in the next cycle.
// A run holds busy through a copy, a scan and a cleanup pass over all N = w*h
// pixels, plus a stack pop with its four neighbor probes (each a memory read
// then an evaluate and write) and a write back per filled hole pixel.
// Reset is synchronous active low; memories hold no reset value.
// The result receiver cannot stall; no output backpressure exists.
// ----------------------------------------------------------------------------
`default_nettype none
module label_map_hole_fill_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_pixel_index,
    input  wire logic [7:0]  i_label_in,
    output logic             o_valid,
    output logic [7:0]       o_label_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    import lhf_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    lhf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_op(i_op),
        .i_status(status), .o_cmd(cmd), .o_busy(busy)
    );

    lhf_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_start(start), .i_op(i_op), .i_pixel_index(i_pixel_index),
        .i_label_in(i_label_in), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_label_out(o_label_out)
    );
endmodule
`default_nettype wire

// ----- rtl/lhf_ram.sv -----
// ----------------------------------------------------------------------------
// lhf_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/lhf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhf_ctrl
// Sequencer of the fill run: copy, background flood, hole scan, cleanup.
// ----------------------------------------------------------------------------
`default_nettype none
module lhf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_op,
    input  wire lhf_pkg::t_status i_status,
    output lhf_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    import lhf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_CP_RD, S_CP_WR, S_GR_INIT, S_POP_CHK, S_POP_RD, S_POP_LD,
        S_NB_RD, S_NB_EV, S_SC_INIT, S_SC_RD, S_SC_EV, S_SC_NEXT, S_WB_INIT,
        S_WB_CHK, S_WB_RD, S_WB_WR, S_FN_INIT, S_FN_RD, S_FN_WR
    } t_state;

    t_state r_state;
    logic   r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= 1'b0;
            o_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_op == OP_RUN) begin
                        r_state <= S_INIT;
                        o_busy  <= 1'b1;
                    end
                end
                S_INIT:    r_state <= S_CP_RD;
                S_CP_RD:   r_state <= S_CP_WR;
                S_CP_WR: begin
                    if (i_status.p_last) begin
                        r_state <= S_GR_INIT;
                        r_scan  <= 1'b0;
                    end else begin
                        r_state <= S_CP_RD;
                    end
                end
                S_GR_INIT: r_state <= S_POP_CHK;
                S_POP_CHK: begin
                    if (i_status.head_lt) r_state <= S_POP_RD;
                    else if (r_scan)      r_state <= S_WB_INIT;
                    else                  r_state <= S_SC_INIT;
                end
                S_POP_RD:  r_state <= S_POP_LD;
                S_POP_LD:  r_state <= S_NB_RD;
                S_NB_RD:   r_state <= S_NB_EV;
                S_NB_EV:   r_state <= i_status.dir_last ? S_POP_CHK : S_NB_RD;
                S_SC_INIT: begin
                    r_state <= S_SC_RD;
                    r_scan  <= 1'b1;
                end
                S_SC_RD:   r_state <= S_SC_EV;
                S_SC_EV: begin
                    if (i_status.fill_zero)   r_state <= S_GR_INIT;
                    else if (i_status.p_last) r_state <= S_FN_INIT;
                    else                      r_state <= S_SC_RD;
                end
                S_SC_NEXT: r_state <= i_status.p_last ? S_FN_INIT : S_SC_RD;
                S_WB_INIT: r_state <= S_WB_CHK;
                S_WB_CHK:  r_state <= i_status.k_lt ? S_WB_RD : S_SC_NEXT;
                S_WB_RD:   r_state <= S_WB_WR;
                S_WB_WR:   r_state <= S_WB_CHK;
                S_FN_INIT: r_state <= S_FN_RD;
                S_FN_RD:   r_state <= S_FN_WR;
                S_FN_WR: begin
                    if (i_status.p_last) begin
                        r_state <= S_IDLE;
                        o_busy  <= 1'b0;
                    end else begin
                        r_state <= S_FN_RD;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:    o_cmd = CMD_IDLE;
            S_INIT:    o_cmd = CMD_RUN_INIT;
            S_CP_RD:   o_cmd = CMD_CP_RD;
            S_CP_WR:   o_cmd = CMD_CP_WR;
            S_GR_INIT: o_cmd = CMD_GR_INIT;
            S_POP_RD:  o_cmd = CMD_POP_RD;
            S_POP_LD:  o_cmd = CMD_POP_LD;
            S_NB_RD:   o_cmd = CMD_NB_RD;
            S_NB_EV:   o_cmd = CMD_NB_EV;
            S_SC_INIT: o_cmd = CMD_P_ZERO;
            S_SC_RD:   o_cmd = CMD_SC_RD;
            S_SC_EV:   o_cmd = CMD_SC_EV;
            S_SC_NEXT: o_cmd = CMD_SC_NEXT;
            S_WB_INIT: o_cmd = CMD_WB_INIT;
            S_WB_RD:   o_cmd = CMD_WB_RD;
            S_WB_WR:   o_cmd = CMD_WB_WR;
            S_FN_INIT: o_cmd = CMD_P_ZERO;
            S_FN_RD:   o_cmd = CMD_FN_RD;
            S_FN_WR:   o_cmd = CMD_FN_WR;
            default:   o_cmd = CMD_NOP;
        endcase
    end

    a_busy_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && i_op == OP_RUN))
        else $error("busy rose without a run request");
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_busy)
        else $error("busy high in idle");
endmodule
`default_nettype wire

// ----- rtl/lhf_dp.sv -----
// ----------------------------------------------------------------------------
// lhf_dp
// Datapath: label, fill and work stack memories, pixel counters, host access.
// ----------------------------------------------------------------------------
`default_nettype none
module lhf_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lhf_pkg::t_cmd          i_cmd,
    output lhf_pkg::t_status            o_status,
    input  wire logic                   i_start,
    input  wire logic [1:0]             i_op,
    input  wire logic [15:0]            i_pixel_index,
    input  wire logic [7:0]             i_label_in,
    input  wire logic                   i_cfg_valid,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [8:0]             i_cfg_data,
    output logic                        o_valid,
    output logic [7:0]                  o_label_out
);
    import lhf_pkg::*;

    logic                 r_fill_enable;
    logic [DIM_W-1:0]     r_cfg_w, r_cfg_h;
    logic [DIM_W-1:0]     r_w;
    logic [COORD_W-1:0]   r_wm1, r_hm1;
    logic [ADDR_W-1:0]    r_p;
    logic [COORD_W-1:0]   r_x, r_y, r_cx, r_cy, r_nx, r_ny;
    logic [1:0]           r_dir;
    logic [CNT_W-1:0]     r_head, r_k, r_count;
    logic [LABEL_W-1:0]   r_best;
    logic [ADDR_W-1:0]    r_q;
    logic                 r_nb_ok;
    logic                 r_rd_fe, r_rd_in;

    logic                 lab_we, fill_we, stk_we;
    logic [ADDR_W-1:0]    lab_raddr, fill_waddr, fill_raddr, stk_waddr, stk_raddr;
    logic [LABEL_W-1:0]   lab_wdata, fill_wdata, lab_rd, fill_rd;
    logic [2*COORD_W-1:0] stk_wdata, stk_rd;

    logic                 host_acc;
    logic [DIM_W-1:0]     eff_w, eff_h;
    logic [CNT_W-1:0]     n_all;
    logic                 border, p_last;
    logic [COORD_W-1:0]   n_nx, n_ny;
    logic                 n_ok;
    logic [CNT_W-1:0]     nb_prod, wb_prod;
    logic [ADDR_W-1:0]    n_q, wb_addr;

    assign host_acc = i_start && (i_cmd == CMD_IDLE);
    assign eff_w    = eff_dim(r_cfg_w);
    assign eff_h    = eff_dim(r_cfg_h);
    assign n_all    = CNT_W'(eff_w) * CNT_W'(eff_h);
    assign border   = (r_x == '0) || (r_y == '0) || (r_x == r_wm1) || (r_y == r_hm1);
    assign p_last   = (r_x == r_wm1) && (r_y == r_hm1);

    always_comb begin
        n_nx = r_cx;
        n_ny = r_cy;
        n_ok = 1'b0;
        case (r_dir)
            DIR_LEFT:  begin n_nx = r_cx - 8'd1; n_ok = (r_cx != '0);    end
            DIR_RIGHT: begin n_nx = r_cx + 8'd1; n_ok = (r_cx != r_wm1); end
            DIR_UP:    begin n_ny = r_cy - 8'd1; n_ok = (r_cy != '0);    end
            default:   begin n_ny = r_cy + 8'd1; n_ok = (r_cy != r_hm1); end
        endcase
    end

    assign nb_prod = CNT_W'(n_ny) * CNT_W'(r_w);
    assign n_q     = ADDR_W'(nb_prod + CNT_W'(n_nx));
    assign wb_prod = CNT_W'(stk_rd[15:8]) * CNT_W'(r_w);
    assign wb_addr = ADDR_W'(wb_prod + CNT_W'(stk_rd[7:0]));

    always_comb begin
        lab_we     = host_acc && (i_op == OP_WRITE);
        lab_wdata  = (i_label_in == MARK) ? TOP_LABEL : i_label_in;
        lab_raddr  = r_p;
        fill_raddr = r_p;
        fill_we    = 1'b0;
        fill_waddr = r_p;
        fill_wdata = MARK;
        stk_we     = 1'b0;
        stk_waddr  = r_count[ADDR_W-1:0];
        stk_wdata  = {r_y, r_x};
        stk_raddr  = r_head[ADDR_W-1:0];
        case (i_cmd)
            CMD_IDLE: begin
                lab_raddr  = i_pixel_index;
                fill_raddr = i_pixel_index;
            end
            CMD_CP_WR: begin
                fill_we = 1'b1;
                if (border && lab_rd == '0) begin
                    stk_we = 1'b1;
                end else begin
                    fill_wdata = lab_rd;
                end
            end
            CMD_NB_RD: begin
                lab_raddr  = n_q;
                fill_raddr = n_q;
            end
            CMD_NB_EV: begin
                fill_waddr = r_q;
                stk_wdata  = {r_ny, r_nx};
                if (r_nb_ok && lab_rd == '0 && fill_rd == '0) begin
                    fill_we = 1'b1;
                    stk_we  = 1'b1;
                end
            end
            CMD_SC_EV: begin
                stk_waddr = '0;
                if (fill_rd == '0) begin
                    fill_we = 1'b1;
                    stk_we  = 1'b1;
                end
            end
            CMD_WB_RD: stk_raddr = r_k[ADDR_W-1:0];
            CMD_WB_WR: begin
                fill_we    = 1'b1;
                fill_waddr = wb_addr;
                fill_wdata = (r_best == MARK) ? '0 : r_best;
            end
            CMD_FN_WR: begin
                fill_wdata = '0;
                fill_we    = (fill_rd == MARK);
            end
            default: ;
        endcase
    end

    // configuration registers, result strobe and work stack count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_enable <= 1'b1;
            r_cfg_w       <= DIM_W'(MAX_DIM);
            r_cfg_h       <= DIM_W'(MAX_DIM);
            r_count       <= '0;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FILL_ENABLE:  r_fill_enable <= i_cfg_data[0];
                    REG_IMAGE_WIDTH:  r_cfg_w       <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_cfg_h       <= i_cfg_data;
                    default: ;
                endcase
            end
            o_valid <= host_acc && (i_op == OP_READ);
            if (stk_we) r_count <= (i_cmd == CMD_SC_EV) ? CNT_W'(1) : r_count + 1'b1;
            if (i_cmd == CMD_RUN_INIT) r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (host_acc) begin
            r_rd_fe <= r_fill_enable;
            r_rd_in <= {1'b0, i_pixel_index} < n_all;
        end
        case (i_cmd)
            CMD_RUN_INIT: begin
                r_w   <= eff_w;
                r_wm1 <= COORD_W'(eff_w - 1'b1);
                r_hm1 <= COORD_W'(eff_h - 1'b1);
                r_p   <= '0;
                r_x   <= '0;
                r_y   <= '0;
            end
            CMD_P_ZERO: begin
                r_p <= '0;
                r_x <= '0;
                r_y <= '0;
            end
            CMD_GR_INIT: begin
                r_head <= '0;
                r_best <= MARK;
            end
            CMD_POP_LD: begin
                r_cy   <= stk_rd[15:8];
                r_cx   <= stk_rd[7:0];
                r_head <= r_head + 1'b1;
                r_dir  <= '0;
            end
            CMD_NB_RD: begin
                r_q     <= n_q;
                r_nx    <= n_nx;
                r_ny    <= n_ny;
                r_nb_ok <= n_ok;
            end
            CMD_NB_EV: begin
                r_dir <= r_dir + 1'b1;
                if (r_nb_ok && lab_rd != '0 && lab_rd < r_best) r_best <= lab_rd;
            end
            CMD_WB_INIT: r_k <= '0;
            CMD_WB_WR:   r_k <= r_k + 1'b1;
            default: ;
        endcase
        // advance the raster position
        if (i_cmd == CMD_CP_WR || i_cmd == CMD_SC_NEXT || i_cmd == CMD_FN_WR ||
            (i_cmd == CMD_SC_EV && fill_rd != '0)) begin
            r_p <= r_p + 1'b1;
            if (r_x == r_wm1) begin
                r_x <= '0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    assign o_label_out = !r_rd_in ? '0 : (r_rd_fe ? fill_rd : lab_rd);

    assign o_status.p_last    = p_last;
    assign o_status.fill_zero = (fill_rd == '0);
    assign o_status.head_lt   = (r_head < r_count);
    assign o_status.dir_last  = (r_dir == DIR_DOWN);
    assign o_status.k_lt      = (r_k < r_count);

    lhf_ram #(.WIDTH(LABEL_W), .DEPTH(STORE_DEPTH)) u_label_ram (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(i_pixel_index), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_rd)
    );
    lhf_ram #(.WIDTH(LABEL_W), .DEPTH(STORE_DEPTH)) u_fill_ram (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_waddr), .i_wdata(fill_wdata),
        .i_raddr(fill_raddr), .o_rdata(fill_rd)
    );
    lhf_ram #(.WIDTH(2*COORD_W), .DEPTH(STORE_DEPTH)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rd)
    );

    a_valid_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && i_cmd == CMD_IDLE && i_op == OP_READ))
        else $error("result without a read request");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("work stack overflow");
    a_push_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_we |-> (fill_we && fill_wdata == MARK))
        else $error("pushed pixel not marked");
endmodule
`default_nettype wire

// ----- verif/label_map_hole_fill_unit_test.sv -----
// ----------------------------------------------------------------------------
// label_map_hole_fill_unit_test
// Self-checking bench: label writes, fill runs and reads on several image
// sizes, checked against an in-bench hole fill predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module label_map_hole_fill_unit_test;
    import lhf_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] idx;
        logic [7:0]  lab;
    } t_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [15:0] i_pixel_index;
    logic [7:0]  i_label_in;
    logic        o_valid;
    logic [7:0]  o_label_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    label_map_hole_fill_unit DUT (.*);

    t_req       pending_reqs[$];
    logic [7:0] label_expect_q[$];
    int         fail_count = 0;
    int         sent_count = 0;
    int         idle_cycles = 0;
    logic       req_taken;

    // predictor state
    logic [7:0] raw_lbl  [0:STORE_DEPTH-1];
    logic [7:0] fill_lbl [0:STORE_DEPTH-1];
    bit         seen     [0:STORE_DEPTH-1];
    int         region[$];
    int         region_min;
    logic [8:0] mdl_en, mdl_w, mdl_h;

    // stimulus-side shadow of what may legally be read
    bit         gen_written [0:STORE_DEPTH-1];
    bit         gen_filled  [0:STORE_DEPTH-1];
    int         gen_w, gen_h;
    bit         gen_en;

    function automatic int clamp_dim(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // grow the zero region held in region[], tracking the smallest plane label
    task grow_region(input int w, input int h);
        int head, p, x, y, b, nx, ny, q;
        head = 0;
        region_min = 255;
        while (head < region.size()) begin
            p = region[head];
            head++;
            x = p % w;
            y = p / w;
            for (b = 0; b < 4; b++) begin
                nx = x + ((b == DIR_LEFT) ? -1 : (b == DIR_RIGHT) ? 1 : 0);
                ny = y + ((b == DIR_UP) ? -1 : (b == DIR_DOWN) ? 1 : 0);
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                q = ny * w + nx;
                if (raw_lbl[q] != 0) begin
                    if (raw_lbl[q] < region_min) region_min = raw_lbl[q];
                end else if (!seen[q]) begin
                    seen[q] = 1;
                    region.push_back(q);
                end
            end
        end
    endtask

    task fill_holes_model();
        int w, h, n, p, x, y, v;
        w = clamp_dim(mdl_w);
        h = clamp_dim(mdl_h);
        n = w * h;
        region.delete();
        for (p = 0; p < n; p++) begin
            seen[p] = 0;
            fill_lbl[p] = raw_lbl[p];
        end
        // border-connected zeros are background
        for (p = 0; p < n; p++) begin
            x = p % w;
            y = p / w;
            if ((x == 0 || y == 0 || x == w - 1 || y == h - 1) && raw_lbl[p] == 0) begin
                seen[p] = 1;
                region.push_back(p);
            end
        end
        grow_region(w, h);
        for (p = 0; p < n; p++) begin
            if (raw_lbl[p] == 0 && !seen[p]) begin
                region.delete();
                seen[p] = 1;
                region.push_back(p);
                grow_region(w, h);
                v = (region_min == 255) ? 0 : region_min;
                foreach (region[k]) fill_lbl[region[k]] = v[7:0];
            end
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_req       r;
        logic [7:0] v;
        int         n;
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FILL_ENABLE:  mdl_en = {8'd0, i_cfg_data[0]};
                    REG_IMAGE_WIDTH:  mdl_w = i_cfg_data;
                    REG_IMAGE_HEIGHT: mdl_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                r = '{op: i_op, idx: i_pixel_index, lab: i_label_in};
                case (r.op)
                    OP_WRITE: raw_lbl[r.idx] = (r.lab == MARK) ? TOP_LABEL : r.lab;
                    OP_RUN:   fill_holes_model();
                    OP_READ: begin
                        n = clamp_dim(mdl_w) * clamp_dim(mdl_h);
                        v = 0;
                        if (r.idx < n) v = mdl_en[0] ? fill_lbl[r.idx] : raw_lbl[r.idx];
                        label_expect_q.push_back(v);
                    end
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (label_expect_q.size() == 0) begin
                    $error("unexpected result label_out=%0d", o_label_out);
                    fail_count++;
                end else begin
                    v = label_expect_q.pop_front();
                    if (o_label_out !== v) begin
                        $error("label_out mismatch: expected %0d actual %0d", v, o_label_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_req r;
        bit   calm;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // hold until accepted
        end else begin
            calm = (sent_count >= 400 && sent_count < 700);
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                r = pending_reqs.pop_front();
                start         <= 1'b1;
                i_op          <= r.op;
                i_pixel_index <= r.idx;
                i_label_in    <= r.lab;
                sent_count++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_label();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 8'd0;
        if (r < 90) return 8'($urandom_range(1, 6));
        return 8'($urandom_range(0, 255));
    endfunction

    task queue_req(input logic [1:0] op, input logic [15:0] idx, input logic [7:0] lab);
        int p;
        pending_reqs.push_back('{op: op, idx: idx, lab: lab});
        if (op == OP_WRITE) gen_written[idx] = 1;
        if (op == OP_RUN)
            for (p = 0; p < gen_w * gen_h; p++) gen_filled[p] = 1;
    endtask

    // every pixel of the image must hold a label before a run
    task queue_run();
        int p;
        for (p = 0; p < gen_w * gen_h; p++)
            if (!gen_written[p]) queue_req(OP_WRITE, p[15:0], pick_label());
        queue_req(OP_RUN, '0, 8'($urandom));
    endtask

    task queue_read();
        int r, n, p;
        bit ok;
        n = gen_w * gen_h;
        r = $urandom_range(99);
        if (r < 70 || n >= STORE_DEPTH) p = $urandom_range(0, n - 1);
        else if (r < 85) p = $urandom_range(0, 65535);
        else p = $urandom_range(n, 65535);
        ok = (p >= n) || (gen_en ? gen_filled[p] : gen_written[p]);
        if (ok) queue_req(OP_READ, p[15:0], 8'($urandom));
        else queue_req(OP_WRITE, p[15:0], pick_label());
    endtask

    task wait_drained();
        int quiet;
        wait (pending_reqs.size() == 0);
        quiet = 0;
        while (quiet < 8) begin
            @(posedge i_clk);
            if (!start && !busy && label_expect_q.size() == 0) quiet++;
            else quiet = 0;
        end
    endtask

    task write_reg(input logic [1:0] index, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task set_image(input logic [8:0] w, input logic [8:0] h, input bit en);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_FILL_ENABLE, {8'd0, en});
        gen_w  = clamp_dim(w);
        gen_h  = clamp_dim(h);
        gen_en = en;
    endtask

    task random_phase(input logic [8:0] w, input logic [8:0] h, input bit en,
                      input int count);
        int i, r, n;
        set_image(w, h, en);
        queue_run();
        n = gen_w * gen_h;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40)
                queue_req(OP_WRITE, ($urandom_range(99) < 70) ?
                          16'($urandom_range(0, n - 1)) : 16'($urandom), pick_label());
            else if (r < 75) queue_read();
            else if (r < 82) queue_run();
            else if (r < 86) queue_req(2'd3, 16'($urandom), 8'($urandom));
            else queue_req(OP_WRITE, 16'($urandom_range(0, n - 1)), 8'($urandom));
        end
    endtask

    initial begin
        int p;
        mdl_en = 9'd1;
        mdl_w  = 9'd256;
        mdl_h  = 9'd256;
        gen_en = 1;
        gen_w  = 256;
        gen_h  = 256;
        start = 0; i_op = '0; i_pixel_index = '0; i_label_in = '0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // 4x4 ring of label 9 with a top-right notch; interior hole also
        // touches a reserved-label pixel that stores as 254
        set_image(9'd4, 9'd4, 1'b1);
        for (p = 0; p < 16; p++)
            queue_req(OP_WRITE, p[15:0], (p == 3 || p == 6 || p == 9 || p == 10) ? 8'd0 :
                      (p == 5) ? MARK : 8'd9);
        queue_req(OP_RUN, '0, 8'hFF);
        for (p = 0; p < 16; p += 3) queue_req(OP_READ, p[15:0], 8'h00);
        queue_req(OP_READ, 16'd10, 8'hFF);
        queue_req(OP_READ, 16'd16, 8'h00);
        queue_req(OP_READ, 16'hFFFF, 8'h00);
        queue_req(2'd3, 16'hFFFF, 8'hFF);
        queue_req(OP_WRITE, 16'hFFFF, 8'hAA);
        set_image(9'd4, 9'd4, 1'b0);
        queue_req(OP_READ, 16'd5, 8'h00);
        queue_req(OP_READ, 16'd6, 8'h00);

        random_phase(9'd8, 9'd8, 1'b1, 90);
        random_phase(9'd16, 9'd12, 1'b1, 120);
        random_phase(9'd5, 9'd5, 1'b0, 60);
        random_phase(9'd1, 9'd1, 1'b1, 30);
        random_phase(9'd0, 9'd0, 1'b1, 20);
        random_phase(9'd256, 9'd2, 1'b1, 90);
        random_phase(9'd2, 9'd256, 1'b1, 90);
        random_phase(9'd511, 9'd1, 1'b1, 30);
        random_phase(9'd1, 9'd511, 1'b0, 30);
        random_phase(9'd12, 9'd9, 1'b1, 120);
        random_phase(9'd20, 9'd20, 1'b1, 150);
        random_phase(9'd7, 9'd3, 1'b1, 60);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && label_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lhf_pkg.sv
rtl/lhf_ram.sv
rtl/lhf_ctrl.sv
rtl/lhf_dp.sv
rtl/label_map_hole_fill_unit.sv
verif/label_map_hole_fill_unit_test.sv
